/* hw/rtl/dfas_pkg.sv */
// ----------------------------------------------------------------------------
// dfas_pkg: shared definitions for the decimal float add/sub unit
// Widths, decimal constants, controller states and control/status bundles.
// ----------------------------------------------------------------------------
package dfas_pkg;

    function automatic longint unsigned f_pow10(input int n);
        longint unsigned p;
        p = 1;
        for (int i = 0; i < n; i++) begin
            p = p * 10;
        end
        return p;
    endfunction

    localparam int MANT_DIGITS = 13;
    localparam int EXP_LIMIT   = 99;

    localparam int MANT_W  = 45;
    localparam int EXP_W   = 8;
    localparam int MAG_W   = MANT_W + 1;   // magnitude of a sum
    localparam int SUM_W   = MANT_W + 2;   // signed sum
    localparam int XEXP_W  = EXP_W + 2;    // exponent with normalization headroom

    localparam int IN_TDATA_W  = ((2 * (MANT_W + EXP_W) + 7) / 8) * 8;
    localparam int OUT_TDATA_W = ((MANT_W + EXP_W + 7) / 8) * 8;
    localparam int IN_TUSER_W  = 1;
    localparam int OUT_TUSER_W = 1;

    localparam logic [MAG_W-1:0] MANT_HI  = MAG_W'(f_pow10(MANT_DIGITS));
    localparam logic [MAG_W-1:0] MANT_LO  = MAG_W'(f_pow10(MANT_DIGITS - 1));
    localparam logic [MAG_W-1:0] MANT_MAX = MAG_W'(f_pow10(MANT_DIGITS) - 1);

    localparam logic signed [XEXP_W-1:0] EXP_MAX = XEXP_W'(EXP_LIMIT);
    localparam logic signed [XEXP_W-1:0] EXP_MIN = XEXP_W'(-EXP_LIMIT);
    localparam logic signed [XEXP_W-1:0] GAP_LIM = XEXP_W'(MANT_DIGITS);

    // divide-by-ten unit: refinement steps after the start cycle
    localparam int DIV_CYC   = 6;
    localparam int DIV_CNT_W = $clog2(DIV_CYC);

    typedef enum logic [3:0] {
        S_IDLE,
        S_CHECK,
        S_ALIGN,
        S_ALIGN_WAIT,
        S_SIGN,
        S_NORM,
        S_NORM_WAIT,
        S_FIN
    } t_state;

    typedef enum logic {
        DIV_SRC_B,
        DIV_SRC_MAG
    } t_div_src;

    typedef struct packed {
        logic     load;
        logic     pass_a;
        logic     pass_b;
        logic     swap;
        logic     div_start;
        t_div_src div_src;
        logic     align_step;
        logic     add;
        logic     take_abs;
        logic     norm_down;
        logic     norm_up;
        logic     finish;
    } t_dp_cmd;

    typedef struct packed {
        logic a_zero;
        logic b_zero;
        logic b_exp_gt;
        logic gap_big;
        logic exp_eq;
        logic div_done;
        logic sum_zero;
        logic mag_hi;
        logic mag_lo;
        logic out_free;
    } t_dp_sts;

endpackage

/* hw/rtl/decimal_float_add_sub.sv */
// ----------------------------------------------------------------------------
// decimal_float_add_sub: 13-digit decimal floating-point adder/subtracter
// Adds or subtracts two signed calculator numbers, truncating alignment,
// renormalizing to 13 digits and saturating on exponent range errors.
// ----------------------------------------------------------------------------
// One item at a time. Alignment and the add are skipped when an operand is
// zero or the exponent gap is 13 or more, normalization is skipped when the
// sum is zero, and a swap of the operands sends the item back through the
// zero and gap check. Each decimal right shift, used for alignment and for a
// carry out of the top digit, runs through the shared divide-by-ten unit, a
// shift-and-add estimate with a one-step correction. The result sits in an
// output register, so a new item is taken as soon as the sequencer is back
// in idle even if the result is still waiting.
// ----------------------------------------------------------------------------
module decimal_float_add_sub import dfas_pkg::*; (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_s_axis_tvalid,
    output logic                   o_s_axis_tready,
    // mant_a[44:0], exp_a[52:45], mant_b[97:53], exp_b[105:98], zero pad
    input  logic [IN_TDATA_W-1:0]  i_s_axis_tdata,
    // func[0]: 0 add, 1 subtract
    input  logic [IN_TUSER_W-1:0]  i_s_axis_tuser,
    output logic                   o_m_axis_tvalid,
    input  logic                   i_m_axis_tready,
    // mant_r[44:0], exp_r[52:45], zero pad
    output logic [OUT_TDATA_W-1:0] o_m_axis_tdata,
    // overflow_err[0]
    output logic [OUT_TUSER_W-1:0] o_m_axis_tuser
);

    t_dp_cmd           cmd;
    t_dp_sts           sts;
    logic [MANT_W-1:0] mant_r;
    logic [EXP_W-1:0]  exp_r;
    logic              overflow_err;

    dfas_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_s_axis_tvalid),
        .o_in_ready (o_s_axis_tready),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    dfas_dp u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (cmd),
        .o_sts          (sts),
        .i_func         (i_s_axis_tuser[0]),
        .i_mant_a       (i_s_axis_tdata[MANT_W-1:0]),
        .i_exp_a        (i_s_axis_tdata[MANT_W+EXP_W-1:MANT_W]),
        .i_mant_b       (i_s_axis_tdata[2*MANT_W+EXP_W-1:MANT_W+EXP_W]),
        .i_exp_b        (i_s_axis_tdata[2*(MANT_W+EXP_W)-1:2*MANT_W+EXP_W]),
        .o_valid        (o_m_axis_tvalid),
        .i_ready        (i_m_axis_tready),
        .o_mant_r       (mant_r),
        .o_exp_r        (exp_r),
        .o_overflow_err (overflow_err)
    );

    assign o_m_axis_tdata = {{(OUT_TDATA_W-MANT_W-EXP_W){1'b0}}, exp_r, mant_r};
    assign o_m_axis_tuser = OUT_TUSER_W'(overflow_err);

endmodule

/* hw/rtl/dfas_div10.sv */
// ----------------------------------------------------------------------------
// dfas_div10: unsigned divide-by-ten unit
// Shift-and-add estimate of x * 0.8, scaled by 1/8, then a remainder check
// that corrects the estimate by one; six steps after the start cycle.
// ----------------------------------------------------------------------------
module dfas_div10 import dfas_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  logic [MAG_W-1:0] i_dividend,
    output logic             o_done,
    output logic [MAG_W-1:0] o_quot
);

    localparam logic [DIV_CNT_W-1:0] STEP_ADD4  = DIV_CNT_W'(0);
    localparam logic [DIV_CNT_W-1:0] STEP_ADD8  = DIV_CNT_W'(1);
    localparam logic [DIV_CNT_W-1:0] STEP_ADD16 = DIV_CNT_W'(2);
    localparam logic [DIV_CNT_W-1:0] STEP_ADD32 = DIV_CNT_W'(3);
    localparam logic [DIV_CNT_W-1:0] STEP_REM   = DIV_CNT_W'(4);
    localparam logic [DIV_CNT_W-1:0] STEP_FIX   = DIV_CNT_W'(5);
    localparam logic [MAG_W-1:0]     DIGIT_MAX  = MAG_W'(9);

    logic                 r_busy;
    logic                 r_done;
    logic [DIV_CNT_W-1:0] r_cnt;
    logic [MAG_W-1:0]     r_num;
    logic [MAG_W-1:0]     r_quot;
    logic                 r_fix;

    logic [MAG_W-1:0]     n_quot;
    logic [MAG_W-1:0]     rem_est;

    // estimate is low by at most one, so the remainder lies in 0..19
    always_comb begin
        rem_est = r_num - MAG_W'({r_quot, 3'b000}) - MAG_W'({r_quot, 1'b0});
        n_quot  = r_quot;
        unique case (r_cnt)
            STEP_ADD4: begin
                n_quot = r_quot + (r_quot >> 4);
            end
            STEP_ADD8: begin
                n_quot = r_quot + (r_quot >> 8);
            end
            STEP_ADD16: begin
                n_quot = r_quot + (r_quot >> 16);
            end
            STEP_ADD32: begin
                n_quot = (r_quot + (r_quot >> 32)) >> 3;
            end
            STEP_REM: begin
                n_quot = r_quot;
            end
            STEP_FIX: begin
                n_quot = r_quot + MAG_W'(r_fix);
            end
            default: begin
                n_quot = r_quot;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == STEP_FIX) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_num  <= i_dividend;
            r_quot <= (i_dividend >> 1) + (i_dividend >> 2);
            r_fix  <= 1'b0;
        end else if (r_busy) begin
            r_quot <= n_quot;
            if (r_cnt == STEP_REM) begin
                r_fix <= (rem_est > DIGIT_MAX);
            end
        end
    end

    assign o_done = r_done;
    assign o_quot = r_quot;

endmodule

/* hw/rtl/dfas_dp.sv */
// ----------------------------------------------------------------------------
// dfas_dp: datapath of the decimal float add/sub unit
// Operand registers, alignment, signed add, normalization and output register.
// ----------------------------------------------------------------------------
module dfas_dp import dfas_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  t_dp_cmd            i_cmd,
    output t_dp_sts            o_sts,
    input  logic               i_func,
    input  logic [MANT_W-1:0]  i_mant_a,
    input  logic [EXP_W-1:0]   i_exp_a,
    input  logic [MANT_W-1:0]  i_mant_b,
    input  logic [EXP_W-1:0]   i_exp_b,
    output logic               o_valid,
    input  logic               i_ready,
    output logic [MANT_W-1:0]  o_mant_r,
    output logic [EXP_W-1:0]   o_exp_r,
    output logic               o_overflow_err
);

    logic                     r_sign_a;
    logic                     r_sign_b;
    logic [MANT_W-1:0]        r_mag_a;
    logic [MANT_W-1:0]        r_mag_b;
    logic signed [XEXP_W-1:0] r_exp_a;
    logic signed [XEXP_W-1:0] r_exp_b;
    logic signed [SUM_W-1:0]  r_sum;
    logic                     r_neg;
    logic [MAG_W-1:0]         r_mag;
    logic signed [XEXP_W-1:0] r_exp;
    logic                     r_chk;

    logic                     r_out_valid;
    logic [MANT_W-1:0]        r_out_mant;
    logic [EXP_W-1:0]         r_out_exp;
    logic                     r_out_err;

    logic [MANT_W-1:0]        in_mag_a;
    logic [MANT_W-1:0]        in_mag_b;
    logic signed [SUM_W-1:0]  val_a;
    logic signed [SUM_W-1:0]  val_b;
    logic [SUM_W-1:0]         sum_abs;
    logic signed [XEXP_W-1:0] gap;
    logic [MAG_W-1:0]         div_in;
    logic                     div_done;
    logic [MAG_W-1:0]         div_quot;
    logic [MAG_W-1:0]         fin_mag;
    logic signed [XEXP_W-1:0] fin_exp;
    logic                     fin_err;
    logic [MAG_W-1:0]         fin_signed;

    assign in_mag_a = i_mant_a[MANT_W-1] ? (~i_mant_a + MANT_W'(1)) : i_mant_a;
    assign in_mag_b = i_mant_b[MANT_W-1] ? (~i_mant_b + MANT_W'(1)) : i_mant_b;

    assign val_a = r_sign_a ? -SUM_W'(r_mag_a) : SUM_W'(r_mag_a);
    assign val_b = r_sign_b ? -SUM_W'(r_mag_b) : SUM_W'(r_mag_b);
    assign sum_abs = r_sum[SUM_W-1] ? -r_sum : r_sum;
    assign gap = r_exp_a - r_exp_b;

    assign div_in = (i_cmd.div_src == DIV_SRC_B) ? MAG_W'(r_mag_b) : r_mag;

    dfas_div10 u_div10 (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (i_cmd.div_start),
        .i_dividend (div_in),
        .o_done     (div_done),
        .o_quot     (div_quot)
    );

    always_comb begin
        fin_mag = r_mag;
        fin_exp = r_exp;
        fin_err = 1'b0;
        if (r_chk && (r_exp > EXP_MAX)) begin
            fin_mag = MANT_MAX;
            fin_exp = EXP_MAX;
            fin_err = 1'b1;
        end else if (r_chk && (r_exp < EXP_MIN)) begin
            fin_mag = MANT_LO;
            fin_exp = EXP_MIN;
            fin_err = 1'b1;
        end
        fin_signed = r_neg ? -fin_mag : fin_mag;
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_sign_a <= i_mant_a[MANT_W-1];
            r_sign_b <= i_mant_b[MANT_W-1] ^ i_func;
            r_mag_a  <= in_mag_a;
            r_mag_b  <= in_mag_b;
            r_exp_a  <= {{(XEXP_W-EXP_W){i_exp_a[EXP_W-1]}}, i_exp_a};
            r_exp_b  <= {{(XEXP_W-EXP_W){i_exp_b[EXP_W-1]}}, i_exp_b};
        end else if (i_cmd.swap) begin
            r_sign_a <= r_sign_b;
            r_sign_b <= r_sign_a;
            r_mag_a  <= r_mag_b;
            r_mag_b  <= r_mag_a;
            r_exp_a  <= r_exp_b;
            r_exp_b  <= r_exp_a;
        end else if (i_cmd.align_step) begin
            r_mag_b <= div_quot[MANT_W-1:0];
            r_exp_b <= r_exp_b + XEXP_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.add) begin
            r_sum <= val_a + val_b;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.pass_a) begin
            r_neg <= r_sign_a;
            r_mag <= MAG_W'(r_mag_a);
            r_exp <= r_exp_a;
            r_chk <= 1'b0;
        end else if (i_cmd.pass_b) begin
            r_neg <= r_sign_b;
            r_mag <= MAG_W'(r_mag_b);
            r_exp <= r_exp_b;
            r_chk <= 1'b0;
        end else if (i_cmd.add) begin
            r_exp <= r_exp_a;
        end else if (i_cmd.take_abs) begin
            r_neg <= r_sum[SUM_W-1];
            r_mag <= sum_abs[MAG_W-1:0];
            r_chk <= (r_sum != '0);
            if (r_sum == '0) begin
                r_exp <= '0;
            end
        end else if (i_cmd.norm_down) begin
            r_mag <= div_quot;
            r_exp <= r_exp + XEXP_W'(1);
        end else if (i_cmd.norm_up) begin
            r_mag <= MAG_W'({r_mag, 3'b000}) + MAG_W'({r_mag, 1'b0});
            r_exp <= r_exp - XEXP_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.finish) begin
            r_out_valid <= 1'b1;
        end else if (i_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.finish) begin
            r_out_mant <= fin_signed[MANT_W-1:0];
            r_out_exp  <= fin_exp[EXP_W-1:0];
            r_out_err  <= fin_err;
        end
    end

    always_comb begin
        o_sts          = '0;
        o_sts.a_zero   = (r_mag_a == '0);
        o_sts.b_zero   = (r_mag_b == '0);
        o_sts.b_exp_gt = (r_exp_b > r_exp_a);
        o_sts.gap_big  = (gap >= GAP_LIM);
        o_sts.exp_eq   = (r_exp_b == r_exp_a);
        o_sts.div_done = div_done;
        o_sts.sum_zero = (r_sum == '0);
        o_sts.mag_hi   = (r_mag >= MANT_HI);
        o_sts.mag_lo   = (r_mag < MANT_LO);
        o_sts.out_free = !r_out_valid || i_ready;
    end

    assign o_valid        = r_out_valid;
    assign o_mant_r       = r_out_mant;
    assign o_exp_r        = r_out_exp;
    assign o_overflow_err = r_out_err;

endmodule

/* hw/rtl/dfas_ctrl.sv */
// ----------------------------------------------------------------------------
// dfas_ctrl: sequencer of the decimal float add/sub unit
// Steps the datapath through zero checks, alignment, add and normalization.
// ----------------------------------------------------------------------------
module dfas_ctrl import dfas_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_in_valid,
    output logic    o_in_ready,
    input  t_dp_sts i_sts,
    output t_dp_cmd o_cmd
);

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_state = S_CHECK;
                end
            end
            S_CHECK: begin
                priority if (i_sts.a_zero || i_sts.b_zero) begin
                    n_state = S_FIN;
                end else if (i_sts.b_exp_gt) begin
                    n_state = S_CHECK;
                end else if (i_sts.gap_big) begin
                    n_state = S_FIN;
                end else begin
                    n_state = S_ALIGN;
                end
            end
            S_ALIGN: begin
                n_state = i_sts.exp_eq ? S_SIGN : S_ALIGN_WAIT;
            end
            S_ALIGN_WAIT: begin
                if (i_sts.div_done) begin
                    n_state = S_ALIGN;
                end
            end
            S_SIGN: begin
                n_state = i_sts.sum_zero ? S_FIN : S_NORM;
            end
            S_NORM: begin
                priority if (i_sts.mag_hi) begin
                    n_state = S_NORM_WAIT;
                end else if (i_sts.mag_lo) begin
                    n_state = S_NORM;
                end else begin
                    n_state = S_FIN;
                end
            end
            S_NORM_WAIT: begin
                if (i_sts.div_done) begin
                    n_state = S_NORM;
                end
            end
            S_FIN: begin
                if (i_sts.out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_comb begin
        o_cmd      = '0;
        o_in_ready = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                o_cmd.load = i_in_valid;
            end
            S_CHECK: begin
                priority if (i_sts.a_zero) begin
                    o_cmd.pass_b = 1'b1;
                end else if (i_sts.b_zero) begin
                    o_cmd.pass_a = 1'b1;
                end else if (i_sts.b_exp_gt) begin
                    o_cmd.swap = 1'b1;
                end else if (i_sts.gap_big) begin
                    o_cmd.pass_a = 1'b1;
                end else begin
                    o_cmd = '0;
                end
            end
            S_ALIGN: begin
                if (i_sts.exp_eq) begin
                    o_cmd.add = 1'b1;
                end else begin
                    o_cmd.div_start = 1'b1;
                    o_cmd.div_src   = DIV_SRC_B;
                end
            end
            S_ALIGN_WAIT: begin
                o_cmd.align_step = i_sts.div_done;
            end
            S_SIGN: begin
                o_cmd.take_abs = 1'b1;
            end
            S_NORM: begin
                priority if (i_sts.mag_hi) begin
                    o_cmd.div_start = 1'b1;
                    o_cmd.div_src   = DIV_SRC_MAG;
                end else if (i_sts.mag_lo) begin
                    o_cmd.norm_up = 1'b1;
                end else begin
                    o_cmd = '0;
                end
            end
            S_NORM_WAIT: begin
                o_cmd.norm_down = i_sts.div_done;
            end
            S_FIN: begin
                o_cmd.finish = i_sts.out_free;
            end
            default: begin
                o_cmd = '0;
            end
        endcase
    end

endmodule

/* tb/decimal_float_add_sub_test.sv */
// ----------------------------------------------------------------------------
// decimal_float_add_sub_test: self-checking bench for the decimal add/sub unit
// A queue of operand items feeds a stream driver; a predictor computes each
// truncated, renormalized and saturated sum, and a monitor compares every
// result item field by field. Both stream sides stall in random bursts.
// ----------------------------------------------------------------------------
module decimal_float_add_sub_test;
    import dfas_pkg::*;

    localparam int  DIGITS     = 13;
    localparam int  LIMIT_EXP  = 99;
    localparam int  DRAIN_CYC  = 200;
    localparam int  MAX_CYCLES = 1000000;
    localparam int  N_RANDOM   = 650;
    localparam int  QUIET_TAIL = 60;

    typedef struct {
        logic                     func;
        logic signed [MANT_W-1:0] mant_a;
        logic signed [EXP_W-1:0]  exp_a;
        logic signed [MANT_W-1:0] mant_b;
        logic signed [EXP_W-1:0]  exp_b;
    } t_operands;

    typedef struct {
        logic signed [MANT_W-1:0] mant;
        logic signed [EXP_W-1:0]  exp;
        logic                     err;
    } t_sum;

    logic                   i_clk;
    logic                   i_rst_n          = 1'b0;
    logic                   i_s_axis_tvalid  = 1'b0;
    logic                   o_s_axis_tready;
    // mant_a, exp_a, mant_b, exp_b, zero pad
    logic [IN_TDATA_W-1:0]  i_s_axis_tdata   = '0;
    // func
    logic [IN_TUSER_W-1:0]  i_s_axis_tuser   = '0;
    logic                   o_m_axis_tvalid;
    logic                   i_m_axis_tready  = 1'b0;
    // mant_r, exp_r, zero pad
    logic [OUT_TDATA_W-1:0] o_m_axis_tdata;
    // overflow_err
    logic [OUT_TUSER_W-1:0] o_m_axis_tuser;

    t_operands operand_queue[$];
    t_sum      expected_sums[$];

    logic item_taken   = 1'b0;
    int   in_gap       = 0;
    int   out_gap      = 0;
    int   burst_odds   = 15;
    int   sent_count   = 0;
    int   result_count = 0;
    int   mismatch_count = 0;
    int   cycle_count  = 0;

    decimal_float_add_sub dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .i_s_axis_tuser  (i_s_axis_tuser),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .o_m_axis_tuser  (o_m_axis_tuser)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Decimal add/sub: truncating alignment, renormalize, saturate.
    function automatic t_sum predict_sum(t_operands op);
        longint ma, mb, ea, eb, rm, re, t, hi, lo;
        bit     neg;
        bit     err;
        t_sum   s;
        ma  = op.mant_a;
        ea  = op.exp_a;
        mb  = op.mant_b;
        eb  = op.exp_b;
        err = 1'b0;
        hi  = 1;
        for (int i = 0; i < DIGITS; i++) begin
            hi = hi * 10;
        end
        lo = hi / 10;
        if (op.func) begin
            mb = -mb;
        end
        if (ma == 0) begin
            rm = mb;
            re = eb;
        end else if (mb == 0) begin
            rm = ma;
            re = ea;
        end else begin
            if (ea < eb) begin
                t = ma; ma = mb; mb = t;
                t = ea; ea = eb; eb = t;
            end
            if (ea - eb >= DIGITS) begin
                rm = ma;
                re = ea;
            end else begin
                while (eb < ea) begin
                    eb++;
                    mb = mb / 10;
                end
                rm = ma + mb;
                re = ea;
                if (rm == 0) begin
                    re = 0;
                end else begin
                    neg = rm < 0;
                    if (neg) begin
                        rm = -rm;
                    end
                    while (rm >= hi) begin
                        rm = rm / 10;
                        re++;
                    end
                    while (rm < lo) begin
                        rm = rm * 10;
                        re--;
                    end
                    if (re > LIMIT_EXP || re < -LIMIT_EXP) begin
                        err = 1'b1;
                        if (re < 0) begin
                            rm = lo;
                            re = -LIMIT_EXP;
                        end else begin
                            rm = hi - 1;
                            re = LIMIT_EXP;
                        end
                    end
                    if (neg) begin
                        rm = -rm;
                    end
                end
            end
        end
        s.mant = rm[MANT_W-1:0];
        s.exp  = re[EXP_W-1:0];
        s.err  = err;
        return s;
    endfunction

    task automatic flag_mismatch(input string msg);
        $display("MISMATCH item %0d: %s", result_count, msg);
        mismatch_count++;
    endtask

    task automatic queue_op(input bit fn, input longint ma, input longint ea,
                            input longint mb, input longint eb);
        t_operands op;
        op.func   = fn;
        op.mant_a = ma[MANT_W-1:0];
        op.exp_a  = ea[EXP_W-1:0];
        op.mant_b = mb[MANT_W-1:0];
        op.exp_b  = eb[EXP_W-1:0];
        operand_queue.push_back(op);
    endtask

    // signed 13-digit mantissa, zero now and then
    function automatic longint random_mant();
        longint unsigned r;
        longint          m;
        r = {$urandom, $urandom};
        if ($urandom_range(0, 99) < 8) begin
            return 0;
        end
        m = 64'sd1000000000000 + longint'(r % 64'd9000000000000);
        return $urandom_range(0, 1) ? -m : m;
    endfunction

    task automatic queue_random_op();
        longint ma, mb, ea, eb;
        int     pick;
        pick = $urandom_range(0, 99);
        if (pick < 10) begin
            queue_op(1'($urandom_range(0, 1)), longint'({$urandom, $urandom}),
                     longint'($urandom), longint'({$urandom, $urandom}),
                     longint'($urandom));
        end else begin
            ma = random_mant();
            if ($urandom_range(0, 9) == 0) begin
                ea = longint'($urandom_range(92, 99));
                if ($urandom_range(0, 1)) ea = -ea;
            end else begin
                ea = longint'($urandom_range(0, 2 * LIMIT_EXP)) - LIMIT_EXP;
            end
            pick = $urandom_range(0, 9);
            if (pick < 7) begin
                eb = ea + longint'($urandom_range(0, 6)) - 3;
            end else if (pick < 9) begin
                eb = ea + longint'($urandom_range(0, 28)) - 14;
            end else begin
                eb = longint'($urandom_range(0, 2 * LIMIT_EXP)) - LIMIT_EXP;
            end
            if (eb > LIMIT_EXP) eb = LIMIT_EXP;
            if (eb < -LIMIT_EXP) eb = -LIMIT_EXP;
            if ($urandom_range(0, 4) == 0 && ma != 0) begin
                // near cancellation
                mb = ma + longint'($urandom_range(0, 2000)) - 1000;
                if ($urandom_range(0, 1)) mb = -mb;
            end else begin
                mb = random_mant();
            end
            queue_op(1'($urandom_range(0, 1)), ma, ea, mb, eb);
        end
    endtask

    // stimulus driver
    always @(negedge i_clk) begin
        t_operands op;
        if (i_rst_n && (!i_s_axis_tvalid || item_taken)) begin
            if (in_gap > 0 || operand_queue.size() == 0) begin
                if (in_gap > 0) in_gap--;
                i_s_axis_tvalid <= 1'b0;
            end else begin
                op = operand_queue.pop_front();
                i_s_axis_tdata  <= IN_TDATA_W'({op.exp_b, op.mant_b, op.exp_a, op.mant_a});
                i_s_axis_tuser  <= op.func;
                i_s_axis_tvalid <= 1'b1;
                sent_count++;
                if (sent_count % 40 == 0) burst_odds = int'($urandom_range(0, 2)) * 15;
                if (operand_queue.size() > QUIET_TAIL && $urandom_range(1, 100) <= burst_odds)
                    in_gap = $urandom_range(1, 8);
            end
        end
    end

    // result-side backpressure
    always @(negedge i_clk) begin
        if (out_gap > 0) begin
            out_gap--;
            i_m_axis_tready <= 1'b0;
        end else begin
            i_m_axis_tready <= 1'b1;
            if (operand_queue.size() > QUIET_TAIL && $urandom_range(1, 100) <= burst_odds / 2)
                out_gap = $urandom_range(1, 8);
        end
    end

    // monitor: predict on input handshake, check on output handshake
    always @(posedge i_clk) begin
        t_sum      got;
        t_sum      want;
        t_operands op;
        if (i_rst_n) begin
            if (o_m_axis_tvalid && i_m_axis_tready) begin
                got.mant = o_m_axis_tdata[MANT_W-1:0];
                got.exp  = o_m_axis_tdata[MANT_W+EXP_W-1:MANT_W];
                got.err  = o_m_axis_tuser[0];
                if (expected_sums.size() == 0) begin
                    flag_mismatch("result item with none expected");
                end else begin
                    want = expected_sums.pop_front();
                    if (got.mant !== want.mant)
                        flag_mismatch($sformatf("mant_r %0d, expected %0d",
                                                got.mant, want.mant));
                    if (got.exp !== want.exp)
                        flag_mismatch($sformatf("exp_r %0d, expected %0d",
                                                got.exp, want.exp));
                    if (got.err !== want.err)
                        flag_mismatch($sformatf("overflow_err %b, expected %b",
                                                got.err, want.err));
                end
                result_count++;
            end
            if (i_s_axis_tvalid && o_s_axis_tready) begin
                op.func   = i_s_axis_tuser[0];
                op.mant_a = i_s_axis_tdata[MANT_W-1:0];
                op.exp_a  = i_s_axis_tdata[MANT_W+EXP_W-1:MANT_W];
                op.mant_b = i_s_axis_tdata[2*MANT_W+EXP_W-1:MANT_W+EXP_W];
                op.exp_b  = i_s_axis_tdata[2*(MANT_W+EXP_W)-1:2*MANT_W+EXP_W];
                expected_sums.push_back(predict_sum(op));
            end
        end
        item_taken <= i_rst_n && i_s_axis_tvalid && o_s_axis_tready;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= MAX_CYCLES) begin
            $display("simulation failed");
            $finish;
        end
    end

    initial begin
        longint big;
        longint one12;
        longint min_m;
        longint max_m;
        big   = 64'sd9999999999999;
        one12 = 64'sd1000000000000;
        min_m = -(64'sd1 <<< (MANT_W - 1));
        max_m = (64'sd1 <<< (MANT_W - 1)) - 1;

        // directed: zero operands, gaps, carry, cancellation, saturation
        queue_op(1'b0, 64'sd1234567890123, 0, 0, 5);
        queue_op(1'b1, 0, 7, -64'sd9876543210987, -3);
        queue_op(1'b0, 0, -99, 0, 99);
        queue_op(1'b0, one12, 20, big, 7);
        queue_op(1'b0, one12, 20, big, 8);
        queue_op(1'b1, 64'sd5555555555555, 3, 64'sd5555555555555, 3);
        queue_op(1'b0, big, 10, big, 10);
        queue_op(1'b1, one12, 5, big, 4);
        queue_op(1'b0, big, 99, big, 99);
        queue_op(1'b1, -big, 99, big, 99);
        queue_op(1'b1, one12 + 1, -99, one12, -99);
        queue_op(1'b1, -one12 - 1, -99, -one12, -99);
        queue_op(1'b1, 0, 0, min_m, -128);
        queue_op(1'b0, max_m, 127, max_m, 127);
        queue_op(1'b0, min_m, -128, 64'sd3, -128);
        queue_op(1'b1, max_m, 127, min_m, -128);
        queue_op(1'b1, 64'sd4444444444444, 6, 64'sd4444444444444, 5);
        queue_op(1'b0, -64'sd7000000000000, -12, 64'sd6123456789012, -10);
        queue_op(1'b0, -1, -1, 1, 127);
        queue_op(1'b0, 64'sd9000000000000, 98, 64'sd2000000000000, 98);
        queue_op(1'b1, 64'sd1000000000000, -90, 64'sd9999999999999, -91);
        queue_op(1'b0, 64'sd1, 0, 64'sd2, 0);
        for (int i = 0; i < N_RANDOM; i++) begin
            queue_random_op();
        end

        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        while (operand_queue.size() != 0 || i_s_axis_tvalid) @(posedge i_clk);
        while (expected_sums.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYC) @(posedge i_clk);

        if (mismatch_count == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end
endmodule

/* files.f */
hw/rtl/dfas_pkg.sv
hw/rtl/dfas_div10.sv
hw/rtl/dfas_dp.sv
hw/rtl/dfas_ctrl.sv
hw/rtl/decimal_float_add_sub.sv
tb/decimal_float_add_sub_test.sv
